[rtl/core/box_frustum_visibility_top_defines.svh]
// ----------------------------------------------------------------------------
// box_frustum_visibility_top_defines
// Assertion macros shared by the box frustum visibility block.
// ----------------------------------------------------------------------------
`ifndef BOX_FRUSTUM_VISIBILITY_TOP_DEFINES_SVH
`define BOX_FRUSTUM_VISIBILITY_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define BFV_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("bfv: same-cycle check failed");

// next-cycle implication, sampled on aclk, off while in reset
`define BFV_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("bfv: next-cycle check failed");

`endif

[rtl/core/bfv_pkg.sv]
// ----------------------------------------------------------------------------
// bfv_pkg
// Types, widths and codes for the box frustum visibility block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfv_pkg;

    // field widths
    localparam int COORD_W   = 20;
    localparam int NORM_W    = 12;
    localparam int OFF_W     = 28;
    localparam int OFF_SHIFT = 10;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = COORD_W + NORM_W;
    localparam int DIST_W    = 39;

    localparam int PLANE_COUNT = 5;
    localparam int PIPE_DEPTH  = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd4;

    // visibility codes
    localparam logic [1:0] VIS_OUTSIDE = 2'd0;
    localparam logic [1:0] VIS_PARTIAL = 2'd1;
    localparam logic [1:0] VIS_INSIDE  = 2'd2;

    // one plane register as stored
    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic signed [OFF_W-1:0]  off;
    } plane_t;

    // one box corner
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic in_en;
        logic prod_en;
        logic sum_en;
        logic sign_en;
        logic out_en;
    } pipe_en_t;

    // exact signed product of a normal component and a coordinate
    function automatic logic signed [PROD_W-1:0] mul_nc(
        input logic signed [NORM_W-1:0]  n,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = PROD_W'(n);
        b = PROD_W'(c);
        return a * b;
    endfunction

    // a strictly positive component takes the minimum as near corner
    function automatic logic is_pos(input logic signed [NORM_W-1:0] n);
        return !n[NORM_W-1] && (n != '0);
    endfunction

endpackage

`default_nettype wire

[rtl/core/bfv_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// bfv_pipe_ctrl
// Valid bits and per-stage load enables of the five-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bfv_pipe_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bfv_pkg::pipe_en_t      en,
    output logic [bfv_pkg::PIPE_DEPTH-1:0] valid_bits
);

    logic [bfv_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic [bfv_pkg::PIPE_DEPTH-1:0] valid_next;
    logic [bfv_pkg::PIPE_DEPTH-1:0] load;

    // a stage loads when empty or when its item moves on
    always_comb begin
        load[bfv_pkg::PIPE_DEPTH-1] = !valid_reg[bfv_pkg::PIPE_DEPTH-1] || m_ready;
        for (int k = bfv_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    // valid bits follow their items
    always_comb begin
        valid_next[0] = load[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < bfv_pkg::PIPE_DEPTH; k++) begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready    = load[0];
    assign m_valid    = valid_reg[bfv_pkg::PIPE_DEPTH-1];
    assign valid_bits = valid_reg;

    assign en.in_en   = load[0];
    assign en.prod_en = load[1];
    assign en.sum_en  = load[2];
    assign en.sign_en = load[3];
    assign en.out_en  = load[4];

endmodule

`default_nettype wire

[rtl/core/bfv_plane_eval.sv]
// ----------------------------------------------------------------------------
// bfv_plane_eval
// Near and far corner distances of a box against one plane, three stages:
// products, partial sums, final sum and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module bfv_plane_eval (
    input  wire logic              aclk,
    input  wire bfv_pkg::pipe_en_t en,
    input  wire bfv_pkg::plane_t   plane,
    input  wire bfv_pkg::vec_t     lo,
    input  wire bfv_pkg::vec_t     hi,
    output logic                   near_neg,
    output logic                   far_neg
);

    bfv_pkg::vec_t near_c;
    bfv_pkg::vec_t far_c;

    logic signed [bfv_pkg::PROD_W-1:0] pn_x_reg, pn_y_reg, pn_z_reg;
    logic signed [bfv_pkg::PROD_W-1:0] pf_x_reg, pf_y_reg, pf_z_reg;
    logic signed [bfv_pkg::DIST_W-1:0] sn_a_reg, sn_b_reg, sf_a_reg, sf_b_reg;
    logic signed [bfv_pkg::DIST_W-1:0] off_ext;
    logic signed [bfv_pkg::DIST_W-1:0] dn_next, df_next;
    logic                              near_neg_reg, far_neg_reg;

    // corner pick by normal signs
    always_comb begin
        near_c.x = bfv_pkg::is_pos(plane.nx) ? lo.x : hi.x;
        near_c.y = bfv_pkg::is_pos(plane.ny) ? lo.y : hi.y;
        near_c.z = bfv_pkg::is_pos(plane.nz) ? lo.z : hi.z;
        far_c.x  = bfv_pkg::is_pos(plane.nx) ? hi.x : lo.x;
        far_c.y  = bfv_pkg::is_pos(plane.ny) ? hi.y : lo.y;
        far_c.z  = bfv_pkg::is_pos(plane.nz) ? hi.z : lo.z;
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (en.prod_en) begin
            pn_x_reg <= bfv_pkg::mul_nc(plane.nx, near_c.x);
            pn_y_reg <= bfv_pkg::mul_nc(plane.ny, near_c.y);
            pn_z_reg <= bfv_pkg::mul_nc(plane.nz, near_c.z);
            pf_x_reg <= bfv_pkg::mul_nc(plane.nx, far_c.x);
            pf_y_reg <= bfv_pkg::mul_nc(plane.ny, far_c.y);
            pf_z_reg <= bfv_pkg::mul_nc(plane.nz, far_c.z);
        end
    end

    // offset aligned to the product fraction bits
    assign off_ext = bfv_pkg::DIST_W'(plane.off) <<< bfv_pkg::OFF_SHIFT;

    // partial sum stage
    always_ff @(posedge aclk) begin
        if (en.sum_en) begin
            sn_a_reg <= bfv_pkg::DIST_W'(pn_x_reg) + bfv_pkg::DIST_W'(pn_y_reg);
            sn_b_reg <= bfv_pkg::DIST_W'(pn_z_reg) + off_ext;
            sf_a_reg <= bfv_pkg::DIST_W'(pf_x_reg) + bfv_pkg::DIST_W'(pf_y_reg);
            sf_b_reg <= bfv_pkg::DIST_W'(pf_z_reg) + off_ext;
        end
    end

    // final sum, keep only the sign
    assign dn_next = sn_a_reg + sn_b_reg;
    assign df_next = sf_a_reg + sf_b_reg;

    always_ff @(posedge aclk) begin
        if (en.sign_en) begin
            near_neg_reg <= dn_next[bfv_pkg::DIST_W-1];
            far_neg_reg  <= df_next[bfv_pkg::DIST_W-1];
        end
    end

    assign near_neg = near_neg_reg;
    assign far_neg  = far_neg_reg;

endmodule

`default_nettype wire

[rtl/core/box_frustum_visibility_top.sv]
// ----------------------------------------------------------------------------
// box_frustum_visibility_top
// Classifies an axis-aligned box against five clipping planes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries one box item (min and max corner,
//   signed Q15.4). Result channel m_valid/m_ready returns one 2-bit
//   visibility code per item, in order: outside, partial or inside.
//   Planes are loaded through cfg_we/cfg_index/cfg_wdata, one 64-bit
//   register per plane; the user must load them only while no item is
//   in flight, which the block does not enforce; indexes above four
//   are dropped. The accepting edge loads the first of five register
//   stages (input register, products, partial sums, final sum and sign,
//   classification); m_valid shows that the last stage holds an item.
//   Throughput: one item per cycle while m_ready is high; the 12x20
//   multipliers and the 39-bit distance adders sit in stages of their own.
//   Reset clears all valid bits and sets every plane to zero, which
//   rejects nothing, so an unconfigured block answers inside.
//   When m_ready is low the pipeline compresses its bubbles and keeps
//   taking items until every stage holds one; then s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_frustum_visibility_top_defines.svh"

module box_frustum_visibility_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [bfv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bfv_pkg::CFG_W-1:0]            cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [bfv_pkg::COORD_W-1:0]   s_lo_x,
    input  wire logic signed [bfv_pkg::COORD_W-1:0]   s_lo_y,
    input  wire logic signed [bfv_pkg::COORD_W-1:0]   s_lo_z,
    input  wire logic signed [bfv_pkg::COORD_W-1:0]   s_hi_x,
    input  wire logic signed [bfv_pkg::COORD_W-1:0]   s_hi_y,
    input  wire logic signed [bfv_pkg::COORD_W-1:0]   s_hi_z,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [1:0]                                m_visibility
);

    bfv_pkg::pipe_en_t                 en;
    logic [bfv_pkg::PIPE_DEPTH-1:0]    valid_bits;
    bfv_pkg::plane_t                   plane_reg [bfv_pkg::PLANE_COUNT];
    bfv_pkg::vec_t                     lo_reg;
    bfv_pkg::vec_t                     hi_reg;
    logic [bfv_pkg::PLANE_COUNT-1:0]   near_neg;
    logic [bfv_pkg::PLANE_COUNT-1:0]   far_neg;
    logic [1:0]                        vis_reg;
    logic [1:0]                        vis_next;

    // plane registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bfv_pkg::PLANE_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                bfv_pkg::REG_PLANE_NEAR:   plane_reg[0] <= cfg_wdata;
                bfv_pkg::REG_PLANE_LEFT:   plane_reg[1] <= cfg_wdata;
                bfv_pkg::REG_PLANE_TOP:    plane_reg[2] <= cfg_wdata;
                bfv_pkg::REG_PLANE_RIGHT:  plane_reg[3] <= cfg_wdata;
                bfv_pkg::REG_PLANE_BOTTOM: plane_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    bfv_pipe_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .en         (en),
        .valid_bits (valid_bits)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (en.in_en) begin
            lo_reg <= '{x: s_lo_x, y: s_lo_y, z: s_lo_z};
            hi_reg <= '{x: s_hi_x, y: s_hi_y, z: s_hi_z};
        end
    end

    // one distance unit per plane
    for (genvar p = 0; p < bfv_pkg::PLANE_COUNT; p++) begin : g_plane
        bfv_plane_eval u_eval (
            .aclk     (aclk),
            .en       (en),
            .plane    (plane_reg[p]),
            .lo       (lo_reg),
            .hi       (hi_reg),
            .near_neg (near_neg[p]),
            .far_neg  (far_neg[p])
        );
    end

    // classification
    always_comb begin
        if (|(near_neg & far_neg)) begin
            vis_next = bfv_pkg::VIS_OUTSIDE;
        end else if (|(near_neg | far_neg)) begin
            vis_next = bfv_pkg::VIS_PARTIAL;
        end else begin
            vis_next = bfv_pkg::VIS_INSIDE;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en.out_en) begin
            vis_reg <= vis_next;
        end
    end

    assign m_visibility = vis_reg;

    // a full, stalled pipeline must hold off the sender
    `BFV_ASSERT_IMP(a_full_stall, (&valid_bits) && !m_ready, !s_ready)
    // an accepted item occupies the first stage next cycle
    `BFV_ASSERT_NXT(a_accept_fills, s_valid && s_ready, valid_bits[0])
    // a delivered result never carries the unused code
    `BFV_ASSERT_IMP(a_vis_code, m_valid, m_visibility <= bfv_pkg::VIS_INSIDE)
    // an empty pipeline cannot present a result next cycle
    `BFV_ASSERT_NXT(a_no_phantom, !(|valid_bits[bfv_pkg::PIPE_DEPTH-2:0]) && !m_valid, !m_valid)

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for box_frustum_visibility_top: boxes are streamed in
// over valid/ready, a local classifier predicts each visibility code from the
// plane registers, and results are compared in order while both channels
// stall at random, except in the last phase, which has no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bfv_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int BOXES_PER_SET  = 117;
    localparam int MAX_REPORTS    = 10;

    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

    localparam logic signed [NORM_W-1:0] NORM_MAX = 12'sh7ff;
    localparam logic signed [NORM_W-1:0] NORM_MIN = 12'sh800;
    localparam logic signed [NORM_W-1:0] NORM_ONE = 12'sh400;
    localparam logic signed [OFF_W-1:0]  OFF_MAX  = 28'sh7ffffff;
    localparam logic signed [OFF_W-1:0]  OFF_MIN  = 28'sh8000000;

    localparam logic signed [NORM_W-1:0] NORM_EDGES [5] =
        '{NORM_MAX, NORM_MIN, 12'sd0, 12'sd1, -12'sd1};
    localparam logic signed [OFF_W-1:0] OFF_EDGES [3] = '{OFF_MAX, OFF_MIN, 28'sd0};

    localparam logic [CFG_IDX_W-1:0] PLANE_REGS [PLANE_COUNT] = '{
        REG_PLANE_NEAR, REG_PLANE_LEFT, REG_PLANE_TOP, REG_PLANE_RIGHT, REG_PLANE_BOTTOM
    };
    // indexes past the plane registers, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(PLANE_COUNT);
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    localparam int TX_IDLE [3] = '{37, 51, 0};
    localparam int RX_IDLE [3] = '{51, 37, 0};

    // expected visibility codes and the plane copy they are computed from
    class cull_scoreboard;
        plane_t     planes [PLANE_COUNT];
        logic [1:0] expected_vis_q [$];
        int         errors;

        function new();
            foreach (planes[i]) planes[i] = '0;
            errors = 0;
        endfunction

        function void write_plane(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx < PLANE_COUNT) planes[idx] = plane_t'(data);
        endfunction

        // near/far corner test against every plane
        function logic [1:0] classify_box(vec_t lo, vec_t hi);
            plane_t p;
            longint nrm [3];
            longint lo_v [3];
            longint hi_v [3];
            longint pos_c [3];
            longint neg_c [3];
            longint d_pos;
            longint d_neg;
            bit     any_neg;
            bit     both_neg;
            lo_v[0] = longint'(lo.x); lo_v[1] = longint'(lo.y); lo_v[2] = longint'(lo.z);
            hi_v[0] = longint'(hi.x); hi_v[1] = longint'(hi.y); hi_v[2] = longint'(hi.z);
            any_neg  = 1'b0;
            both_neg = 1'b0;
            for (int i = 0; i < PLANE_COUNT; i++) begin
                p = planes[i];
                nrm[0] = longint'(p.nx); nrm[1] = longint'(p.ny); nrm[2] = longint'(p.nz);
                // zero component picks like a negative one
                for (int a = 0; a < 3; a++) begin
                    if (nrm[a] > 0) begin
                        pos_c[a] = lo_v[a];
                        neg_c[a] = hi_v[a];
                    end else begin
                        pos_c[a] = hi_v[a];
                        neg_c[a] = lo_v[a];
                    end
                end
                d_pos = nrm[0] * pos_c[0] + nrm[1] * pos_c[1] + nrm[2] * pos_c[2]
                      + (longint'(p.off) <<< OFF_SHIFT);
                d_neg = nrm[0] * neg_c[0] + nrm[1] * neg_c[1] + nrm[2] * neg_c[2]
                      + (longint'(p.off) <<< OFF_SHIFT);
                if (d_pos < 0 || d_neg < 0) any_neg = 1'b1;
                if (d_pos < 0 && d_neg < 0) both_neg = 1'b1;
            end
            if (both_neg) return VIS_OUTSIDE;
            if (any_neg) return VIS_PARTIAL;
            return VIS_INSIDE;
        endfunction

        function void note_box(vec_t lo, vec_t hi);
            expected_vis_q.push_back(classify_box(lo, hi));
        endfunction

        function void check_result(logic [1:0] vis);
            logic [1:0] exp_vis;
            if (expected_vis_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: visibility %0d with no box pending", $time, vis);
            end else begin
                exp_vis = expected_vis_q.pop_front();
                if (vis !== exp_vis) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: visibility expected %0d got %0d",
                                 $time, exp_vis, vis);
                end
            end
        endfunction

        function int pending_count();
            return expected_vis_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    vec_t                 box_lo    = '0;
    vec_t                 box_hi    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [1:0]           m_visibility;

    int tx_idle_pct = TX_IDLE[0];
    int rx_idle_pct = RX_IDLE[0];
    int cycle_count = 0;

    cull_scoreboard sb = new();

    box_frustum_visibility_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_lo_x       (box_lo.x),
        .s_lo_y       (box_lo.y),
        .s_lo_z       (box_lo.z),
        .s_hi_x       (box_hi.x),
        .s_hi_y       (box_hi.y),
        .s_hi_z       (box_hi.z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_visibility (m_visibility)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // random result back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watch both handshakes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_box(box_lo, box_hi);
            if (m_valid && m_ready) sb.check_result(m_visibility);
        end
    end

    // run time limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[box_frustum_visibility_top] ERROR");
        $finish;
    end

    function automatic logic [CFG_W-1:0] make_plane(
        logic signed [NORM_W-1:0] nx,
        logic signed [NORM_W-1:0] ny,
        logic signed [NORM_W-1:0] nz,
        logic signed [OFF_W-1:0]  off
    );
        return {nx, ny, nz, off};
    endfunction

    function automatic vec_t corner(int x, int y, int z);
        vec_t v;
        v.x = COORD_W'(x);
        v.y = COORD_W'(y);
        v.z = COORD_W'(z);
        return v;
    endfunction

    // signed value of random magnitude, up to w bits
    function automatic int rand_scaled(int w);
        int r;
        int k;
        r = $urandom;
        k = $urandom_range(w, 1);
        return r >>> (32 - k);
    endfunction

    // mostly real planes, some zero or extreme ones
    function automatic logic [CFG_W-1:0] rand_plane();
        plane_t p;
        int     pick;
        pick = $urandom_range(19);
        if (pick < 3) begin
            p = '0;
        end else if (pick < 6) begin
            p.nx  = NORM_EDGES[$urandom_range(4)];
            p.ny  = NORM_EDGES[$urandom_range(4)];
            p.nz  = NORM_EDGES[$urandom_range(4)];
            p.off = OFF_EDGES[$urandom_range(2)];
        end else begin
            p.nx  = NORM_W'($urandom);
            p.ny  = NORM_W'($urandom);
            p.nz  = NORM_W'($urandom);
            p.off = OFF_W'(rand_scaled(OFF_W));
        end
        return p;
    endfunction

    // boxes of random size and place, some points, some full-range noise
    function automatic void rand_box(output vec_t lo, output vec_t hi);
        logic signed [COORD_W-1:0] l [3];
        logic signed [COORD_W-1:0] h [3];
        int pick;
        pick = $urandom_range(9);
        for (int a = 0; a < 3; a++) begin
            if (pick < 2) begin
                l[a] = COORD_W'($urandom);
                h[a] = COORD_W'($urandom);
            end else if (pick == 2) begin
                l[a] = COORD_W'(rand_scaled(COORD_W));
                h[a] = l[a];
            end else begin
                l[a] = COORD_W'(rand_scaled(COORD_W));
                h[a] = l[a] + COORD_W'($urandom_range(1 << $urandom_range(14, 0)));
            end
        end
        lo = '{l[0], l[1], l[2]};
        hi = '{h[0], h[1], h[2]};
    endfunction

    // write enable is left high, callers lower it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_plane(idx, data);
    endtask

    task automatic load_planes(input logic [CFG_W-1:0] vals [PLANE_COUNT]);
        for (int i = 0; i < PLANE_COUNT; i++) write_reg(PLANE_REGS[i], vals[i]);
        cfg_we <= 1'b0;
    endtask

    // offer one item, idling first at random
    task automatic send_box(input vec_t lo, input vec_t hi);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        box_lo  <= lo;
        box_hi  <= hi;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and let every pending result come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (2 * PIPE_DEPTH) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        logic [CFG_W-1:0] plane_set [PLANE_COUNT];
        vec_t lo;
        vec_t hi;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // writes past the last plane must not reject anything
        write_reg(REG_FIRST_UNUSED, make_plane(NORM_MAX, NORM_MAX, NORM_MAX, OFF_MIN));
        write_reg(REG_LAST_UNUSED, make_plane(NORM_MIN, NORM_MIN, NORM_MIN, OFF_MIN));
        cfg_we <= 1'b0;

        // zero planes answer inside for anything
        send_box(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(corner(0, 0, 0), corner(0, 0, 0));
        send_box(corner(COORD_MAX, COORD_MAX, COORD_MAX), corner(COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(corner(COORD_MIN, 0, COORD_MAX), corner(COORD_MAX, 0, COORD_MIN));
        wait_idle();

        // cube of half width 100 with no far plane, normals on the axes
        plane_set = '{
            make_plane(12'sd0, 12'sd0, NORM_ONE, 28'sd100),
            make_plane(NORM_ONE, 12'sd0, 12'sd0, 28'sd100),
            make_plane(12'sd0, -NORM_ONE, 12'sd0, 28'sd100),
            make_plane(-NORM_ONE, 12'sd0, 12'sd0, 28'sd100),
            make_plane(12'sd0, NORM_ONE, 12'sd0, 28'sd100)
        };
        load_planes(plane_set);
        send_box(corner(-10, -10, -10), corner(10, 10, 10));
        send_box(corner(90, 0, 0), corner(110, 10, 10));
        send_box(corner(150, 0, 0), corner(200, 10, 10));
        send_box(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(corner(100, 0, 0), corner(100, 0, 0));
        send_box(corner(101, 0, 0), corner(101, 0, 0));
        send_box(corner(10, 10, 10), corner(-10, -10, -10));
        send_box(corner(0, 0, 5000), corner(0, 0, 5000));
        send_box(corner(0, 0, -101), corner(0, 0, -101));
        wait_idle();

        // extreme normals and offsets
        plane_set = '{
            make_plane(NORM_MAX, NORM_MAX, NORM_MAX, 28'sd0),
            make_plane(NORM_MIN, NORM_MIN, NORM_MIN, 28'sd0),
            make_plane(NORM_MAX, NORM_MIN, 12'sd0, OFF_MAX),
            make_plane(NORM_MIN, NORM_MAX, NORM_MAX, OFF_MAX),
            make_plane(12'sd0, 12'sd0, NORM_MIN, OFF_MIN)
        };
        load_planes(plane_set);
        send_box(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(corner(COORD_MAX, COORD_MAX, COORD_MAX), corner(COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(corner(COORD_MIN, 0, 0), corner(COORD_MAX, 0, 0));
        send_box(corner(COORD_MAX, COORD_MAX, COORD_MAX), corner(COORD_MIN, COORD_MIN, COORD_MIN));
        wait_idle();

        // random planes and boxes under each idling pattern
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = TX_IDLE[mode];
            rx_idle_pct = RX_IDLE[mode];
            repeat (2) begin
                foreach (plane_set[i]) plane_set[i] = rand_plane();
                load_planes(plane_set);
                repeat (BOXES_PER_SET) begin
                    rand_box(lo, hi);
                    send_box(lo, hi);
                end
                wait_idle();
            end
        end

        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("[box_frustum_visibility_top] OK");
        end else begin
            $display("[box_frustum_visibility_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
